/* design/checkerboard_alpha_composite_defines.svh */
// assertion macros used by the top-level design file
`ifndef CHECKERBOARD_ALPHA_COMPOSITE_DEFINES_SVH
`define CHECKERBOARD_ALPHA_COMPOSITE_DEFINES_SVH

// same-cycle implication
`define CAC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define CAC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/cac_pkg.sv */
package cac_pkg;

    localparam int CFG_DIM_W = 13;
    localparam int CFG_IDX_W = 2;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_LW    = $clog2(Q_DEPTH + 1);

    localparam int CHK_BIT = 3;
    localparam logic [7:0] CHK_LIGHT    = 8'd255;
    localparam logic [7:0] CHK_DARK     = 8'd192;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH   = 2'd0,
        CFG_FRAME_HEIGHT  = 2'd1,
        CFG_GRAY_MODE     = 2'd2,
        CFG_ALPHA_PRESENT = 2'd3
    } cfg_index_t;

    // ch[0] blue or gray, ch[1] green or gray, ch[2] red or gray
    typedef struct packed {
        logic [2:0][7:0] ch;
        logic [7:0]      alpha;
        logic            chk_dark;
        logic            blend;
        logic            last;
    } cac_item_t;

    typedef struct packed {
        logic col_zero;
        logic row_zero;
        logic frame_done;
    } fr_stat_t;

endpackage

/* design/cac_front.sv */
module cac_front #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr,
    input  logic [cac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cac_pkg::CFG_DIM_W-1:0]  cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,
    input  logic                           q_full,
    output logic                           q_push,
    output cac_pkg::cac_item_t             q_item,
    output cac_pkg::fr_stat_t              stat
);
    import cac_pkg::*;

    localparam int CW = $clog2(MAX_DIMENSION);
    localparam int DW = CW + 1;

    logic [CFG_DIM_W-1:0] width_reg;
    logic [CFG_DIM_W-1:0] height_reg;
    logic                 gray_reg;
    logic                 alpha_en_reg;
    logic [CW-1:0]        col_reg, col_next;
    logic [CW-1:0]        row_reg, row_next;

    logic [DW-1:0] w_eff, h_eff;
    logic          row_end, frame_done, accept;
    logic [7:0]    red, green, blue, alpha;

    function automatic logic [DW-1:0] eff_dim(input logic [CFG_DIM_W-1:0] v);
        logic [DW-1:0] d;
        if (32'(v) > 32'(MAX_DIMENSION))
            d = DW'(MAX_DIMENSION);
        else
            d = DW'(v);
        d[1:0] = 2'b00;
        if (d == '0)
            d = DW'(4);
        return d;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= CFG_DIM_W'(4096);
            height_reg   <= CFG_DIM_W'(4096);
            gray_reg     <= 1'b0;
            alpha_en_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_FRAME_WIDTH:   width_reg    <= cfg_data;
                CFG_FRAME_HEIGHT:  height_reg   <= cfg_data;
                CFG_GRAY_MODE:     gray_reg     <= cfg_data[0];
                CFG_ALPHA_PRESENT: alpha_en_reg <= cfg_data[0];
            endcase
        end
    end

    assign w_eff = eff_dim(width_reg);
    assign h_eff = eff_dim(height_reg);

    assign red   = s_tdata[7:0];
    assign green = s_tdata[15:8];
    assign blue  = s_tdata[23:16];
    assign alpha = s_tdata[31:24];

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // counters may sit past the frame after a size change mid-frame
    assign row_end    = {1'b0, col_reg} >= (w_eff - DW'(1));
    assign frame_done = row_end && ({1'b0, row_reg} >= (h_eff - DW'(1)));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (row_end)
        begin
            col_next = '0;
            row_next = frame_done ? '0 : row_reg + CW'(1);
        end
        else
        begin
            col_next = col_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_comb
    begin
        q_item.ch[2]    = red;
        q_item.ch[1]    = gray_reg ? red : green;
        q_item.ch[0]    = gray_reg ? red : blue;
        q_item.alpha    = alpha;
        q_item.chk_dark = col_reg[CHK_BIT] != row_reg[CHK_BIT];
        q_item.blend    = alpha_en_reg && (alpha != ALPHA_OPAQUE);
        q_item.last     = frame_done;
    end

    assign q_push = accept;

    assign stat.col_zero   = col_reg == '0;
    assign stat.row_zero   = row_reg == '0;
    assign stat.frame_done = frame_done;

endmodule

/* design/cac_queue.sv */
module cac_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  cac_pkg::cac_item_t         push_item,
    input  logic                       pop,
    output cac_pkg::cac_item_t         head_item,
    output logic                       empty,
    output logic                       full,
    output logic [cac_pkg::Q_LW-1:0]   level
);
    import cac_pkg::*;

    cac_item_t         slot_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_LW-1:0]   level_reg, level_next;

    assign empty     = level_reg == '0;
    assign full      = level_reg == Q_LW'(Q_DEPTH);
    assign level     = level_reg;
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        level_next = level_reg;
        if (push && !pop)
            level_next = level_reg + Q_LW'(1);
        else if (pop && !push)
            level_next = level_reg - Q_LW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            level_reg <= level_next;
        end
    end

endmodule

/* design/cac_back.sv */
module cac_back (
    input  logic                clk,
    input  logic                rst_n,
    input  cac_pkg::cac_item_t  head_item,
    input  logic                q_empty,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,
    output logic                m_tlast
);
    import cac_pkg::*;

    logic            s1_valid_reg;
    logic [15:0]     s1_sum_reg  [3];
    logic [7:0]      s1_pass_reg [3];
    logic            s1_blend_reg;
    logic            s1_last_reg;

    logic            out_valid_reg;
    logic [23:0]     out_data_reg, out_data_next;
    logic            out_last_reg;

    logic            out_en, s1_en;
    logic [7:0]      chk, a_inv;
    logic [15:0]     sum [3];
    logic [16:0]     quo [3];

    assign out_en = !out_valid_reg || m_tready;
    assign s1_en  = !s1_valid_reg || out_en;
    assign q_pop  = s1_en && !q_empty;

    assign chk   = head_item.chk_dark ? CHK_DARK : CHK_LIGHT;
    assign a_inv = ALPHA_OPAQUE - head_item.alpha;

    // weighted sum stays below 65536
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sum[i] = (16'(a_inv) * 16'(chk)) + (16'(head_item.alpha) * 16'(head_item.ch[i]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_en)
            s1_valid_reg <= !q_empty;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_sum_reg[i]  <= sum[i];
                s1_pass_reg[i] <= head_item.ch[i];
            end
            s1_blend_reg <= head_item.blend;
            s1_last_reg  <= head_item.last;
        end
    end

    // x / 255 as (x + (x >> 8) + 1) >> 8, exact for every weighted sum (at most 65025)
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            quo[i] = 17'(s1_sum_reg[i]) + 17'(s1_sum_reg[i][15:8]) + 17'(1);
            out_data_next[i*8 +: 8] = s1_blend_reg ? quo[i][15:8] : s1_pass_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_en)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_en && s1_valid_reg)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* design/checkerboard_alpha_composite.sv */
// path: an accepted beat is written into the queue, then passes the blend stage and
// the output register before it is offered on the master side
// throughput: one pixel per clock without master stalls; a four-entry queue absorbs them
// reset: counters to pixel zero, frame size 4096 x 4096, rgb input, alpha off,
// queue and pipeline emptied; no clearing pass
`include "checkerboard_alpha_composite_defines.svh"

module checkerboard_alpha_composite #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cac_pkg::CFG_DIM_W-1:0]  cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // red_or_gray, green, blue, alpha
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,   // out_first, out_second, out_third
    output logic                           m_tlast
);
    import cac_pkg::*;

    logic              q_push, q_pop, q_empty, q_full;
    cac_item_t         push_item, head_item;
    logic [Q_LW-1:0]   q_level;
    fr_stat_t          stat;

    assign cfg_ready = 1'b1;

    cac_front #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item),
        .stat      (stat)
    );

    cac_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .empty     (q_empty),
        .full      (q_full),
        .level     (q_level)
    );

    cac_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_item (head_item),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    `CAC_ASSERT_NEXT(a_accept_lands, s_tvalid && s_tready, q_level != '0)
    `CAC_ASSERT_NOW(a_queue_bound, 1'b1, q_level <= Q_LW'(Q_DEPTH))
    `CAC_ASSERT_NEXT(a_frame_wrap, s_tvalid && s_tready && stat.frame_done, stat.col_zero && stat.row_zero)

endmodule

/* dv/checkerboard_alpha_composite_tb.sv */
`timescale 1ns / 100ps

import cac_pkg::*;

class pixel_scoreboard;

    typedef struct packed {
        logic [7:0] out_first;
        logic [7:0] out_second;
        logic [7:0] out_third;
        logic       frame_end;
    } display_pixel_t;

    logic [CFG_DIM_W-1:0] width_reg;
    logic [CFG_DIM_W-1:0] height_reg;
    logic                 gray_reg;
    logic                 alpha_reg;
    int unsigned          column;
    int unsigned          row;
    display_pixel_t       expected_q[$];
    int unsigned          errors;

    function new();
        width_reg  = 13'd4096;
        height_reg = 13'd4096;
        gray_reg   = 1'b0;
        alpha_reg  = 1'b0;
        column     = 0;
        row        = 0;
        errors     = 0;
    endfunction

    function void write_register(cfg_index_t idx, logic [CFG_DIM_W-1:0] value);
        case (idx)
            CFG_FRAME_WIDTH:   width_reg  = value;
            CFG_FRAME_HEIGHT:  height_reg = value;
            CFG_GRAY_MODE:     gray_reg   = value[0];
            CFG_ALPHA_PRESENT: alpha_reg  = value[0];
            default: ;
        endcase
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    // saturate, round down to a multiple of four, never below four
    static function int unsigned effective_dim(logic [CFG_DIM_W-1:0] value);
        int unsigned d;
        d = (value > 4096) ? 4096 : value;
        d = d & ~32'd3;
        if (d == 0)
            d = 4;
        return d;
    endfunction

    static function logic [7:0] blend(int unsigned v, int unsigned a, int unsigned c);
        return 8'(((255 - a) * c + a * v) / 255);
    endfunction

    function void note_pixel(logic [31:0] beat);
        logic [7:0]     r;
        logic [7:0]     g;
        logic [7:0]     b;
        logic [7:0]     a;
        logic [7:0]     level;
        int unsigned    w;
        int unsigned    h;
        logic           row_end;
        logic           done;
        display_pixel_t p;
        r = beat[7:0];
        g = beat[15:8];
        b = beat[23:16];
        a = beat[31:24];
        if (gray_reg)
        begin
            g = r;
            b = r;
        end
        if (alpha_reg && a != ALPHA_OPAQUE)
        begin
            level = (column[CHK_BIT] == row[CHK_BIT]) ? CHK_LIGHT : CHK_DARK;
            p.out_first  = blend(b, a, level);
            p.out_second = blend(g, a, level);
            p.out_third  = blend(r, a, level);
        end
        else
        begin
            p.out_first  = b;
            p.out_second = g;
            p.out_third  = r;
        end
        w = effective_dim(width_reg);
        h = effective_dim(height_reg);
        row_end = (column >= w - 1);
        done    = row_end && (row >= h - 1);
        if (row_end)
        begin
            column = 0;
            row    = done ? 0 : row + 1;
        end
        else
            column = column + 1;
        p.frame_end = done;
        expected_q.push_back(p);
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    endfunction

    function void check_pixel(logic [23:0] data, logic last);
        display_pixel_t want;
        if (expected_q.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected beat, expected none actual data %h last %b",
                     $time, data, last);
            return;
        end
        want = expected_q.pop_front();
        if (data[7:0] !== want.out_first)
            report("out_first", want.out_first, data[7:0]);
        if (data[15:8] !== want.out_second)
            report("out_second", want.out_second, data[15:8]);
        if (data[23:16] !== want.out_third)
            report("out_third", want.out_third, data[23:16]);
        if (last !== want.frame_end)
            report("frame_end", want.frame_end, last);
    endfunction

endclass

module checkerboard_alpha_composite_tb;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_ITEMS = 1600;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DIM_W-1:0] cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [23:0]          m_tdata;
    logic                 m_tlast;

    int unsigned     src_idle_pct  = 0;
    int unsigned     sink_stall_pct = 0;
    int unsigned     cycle_count   = 0;
    pixel_scoreboard sb            = new();

    checkerboard_alpha_composite DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // display side: check accepted beats, then pick next ready
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_pixel(m_tdata, m_tlast);
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // leaves cfg_valid high; the caller lowers it after the last write
    task cfg_beat(cfg_index_t idx, logic [CFG_DIM_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_register(idx, value);
    endtask

    task apply_config(bit w_en, logic [CFG_DIM_W-1:0] w, bit h_en, logic [CFG_DIM_W-1:0] h,
                      bit g_en, logic [CFG_DIM_W-1:0] g, bit a_en, logic [CFG_DIM_W-1:0] a);
        if (w_en)
            cfg_beat(CFG_FRAME_WIDTH, w);
        if (h_en)
            cfg_beat(CFG_FRAME_HEIGHT, h);
        if (g_en)
            cfg_beat(CFG_GRAY_MODE, g);
        if (a_en)
            cfg_beat(CFG_ALPHA_PRESENT, a);
        cfg_valid <= 1'b0;
    endtask

    task push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {a, b, g, r};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_pixel({a, b, g, r});
    endtask

    task wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task set_idling(int unsigned mode);
        case (mode)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 74; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 74; end
            default: begin src_idle_pct = 35; sink_stall_pct = 35; end
        endcase
    endtask

    task push_random_pixel();
        logic [7:0] a;
        case ($urandom_range(3))
            0: a = 8'd0;
            1: a = ALPHA_OPAQUE;
            default: a = 8'($urandom_range(255));
        endcase
        push_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), a);
    endtask

    initial
    begin
        int unsigned sent;
        int unsigned phase;
        int unsigned n;
        logic [CFG_DIM_W-1:0] w;
        logic [CFG_DIM_W-1:0] h;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: rgb pass-through on a 4096 x 4096 frame
        push_pixel(8'hff, 8'hff, 8'hff, 8'hff);
        push_pixel(8'h55, 8'haa, 8'h0f, 8'h00);

        // widths and heights below four, alpha blending on rgb
        wait_drained();
        apply_config(1, 13'd3, 1, 13'd0, 1, 13'd0, 1, 13'd1);
        push_pixel(8'hff, 8'h00, 8'h80, 8'd0);
        push_pixel(8'h00, 8'hff, 8'h12, ALPHA_OPAQUE);
        push_pixel(8'hff, 8'hff, 8'hff, 8'd1);
        push_pixel(8'h00, 8'h00, 8'h00, 8'd254);
        push_pixel(8'h9c, 8'h3e, 8'h71, 8'd128);

        // gray replication, with blending
        wait_drained();
        apply_config(0, '0, 0, '0, 1, 13'd1, 0, '0);
        push_pixel(8'hff, 8'h00, 8'h00, 8'd0);
        push_pixel(8'h00, 8'hff, 8'hff, 8'd77);
        push_pixel(8'h5a, 8'h12, 8'h34, ALPHA_OPAQUE);

        // run past column 8 for the dark checker, then shrink the row mid-frame
        wait_drained();
        apply_config(1, 13'd32, 1, 13'd2, 1, 13'd0, 0, '0);
        repeat (10) push_pixel(8'hff, 8'h80, 8'h00, 8'd100);
        wait_drained();
        apply_config(1, 13'd8, 0, '0, 0, '0, 0, '0);
        repeat (3) push_pixel(8'h00, 8'hff, 8'h40, 8'd200);

        // dimensions above the limit saturate
        wait_drained();
        apply_config(1, 13'd8191, 1, 13'd8191, 0, '0, 0, '0);
        push_pixel(8'h01, 8'h02, 8'h03, 8'd0);
        push_pixel(8'hfe, 8'hfd, 8'hfc, 8'd255);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_drained();
            case ($urandom_range(9))
                0: w = 13'($urandom_range(3));
                1: w = 13'd4096;
                2: w = 13'($urandom_range(8191));
                default: w = 13'($urandom_range(4, 20));
            endcase
            case ($urandom_range(9))
                0: h = 13'($urandom_range(3));
                1: h = 13'($urandom_range(4097, 8191));
                default: h = 13'($urandom_range(4, 10));
            endcase
            apply_config($urandom_range(9) < 6, w, $urandom_range(9) < 6, h,
                         $urandom_range(1), 13'($urandom_range(8191)),
                         $urandom_range(1), 13'($urandom_range(8191)));
            set_idling(phase % 4);
            n = $urandom_range(20, 60);
            repeat (n) push_random_pixel();
            sent += n;
            phase++;
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
